### design/assert_macros.svh
// Assertion macros used by the Sobel core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGOB_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SGOB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/sgob_pkg.sv
// Shared constants, types and functions of the Sobel orientation block.
`timescale 1ns / 1ps
package sgob_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int IDX_W     = $clog2(MAX_WIDTH);
   localparam int PIXEL_W   = 8;
   localparam int COORD_W   = 10;
   localparam int MAG_W     = 11;
   localparam int DIR_W     = 3;
   localparam int CFG_W     = 11;
   localparam int MAX_HEIGHT = 1024;
   localparam int ROW_W     = 10;
   localparam int GRAD_W    = 11;
   localparam int SQ_W      = 22;
   localparam int CROSS_W   = 30;
   localparam int SQRT_STEPS = SQ_W / 2;
   localparam int STEP_W    = $clog2(SQRT_STEPS);
   localparam int EXT_W     = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;

   // Q2.16 tangents of the sector edges
   localparam int ONE_Q16 = 65536;
   localparam int T10     = 11556;
   localparam int T20     = 23853;
   localparam int T40     = 54991;
   localparam int T60     = 113512;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [DIR_W-1:0] DIR_VERT     = 3'd2;
   localparam logic [DIR_W-1:0] DIR_DIAG_NEG = 3'd3;
   localparam logic [DIR_W-1:0] DIR_HORZ     = 3'd4;
   localparam logic [DIR_W-1:0] DIR_DIAG_POS = 3'd5;

   localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd150;

   // Map half-plane and count of passed edges to a direction code.
   function automatic logic [DIR_W-1:0] sector_code(input logic upper, input logic [2:0] k);
      logic [DIR_W-1:0] code;
      code = DIR_HORZ;
      unique case (k)
         3'd0: code = DIR_HORZ;
         3'd1: code = upper ? DIR_DIAG_POS : DIR_DIAG_NEG;
         3'd2: code = DIR_VERT;
         3'd3: code = upper ? DIR_DIAG_NEG : DIR_DIAG_POS;
         default: code = DIR_HORZ;
      endcase
      return code;
   endfunction

endpackage

### design/sgob_if.sv
// Stream interfaces for the pixel and result channels.
`timescale 1ns / 1ps
interface sgob_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface sgob_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_valid;
   logic [9:0]  out_col;
   logic [9:0]  out_row;
   logic [10:0] magnitude;
   logic [2:0]  direction;
   modport source (output valid, output out_valid, output out_col, output out_row,
                   output magnitude, output direction, input ready);
   modport sink   (input valid, input out_valid, input out_col, input out_row,
                   input magnitude, input direction, output ready);
endinterface

### design/sobel_gradient_orientation_bin_core.sv
// Sobel gradient magnitude and orientation core over a raster pixel stream.
//
//  channel      direction  transaction
//  req_channel  in         one gray pixel, raster order
//  rsp_channel  out        one result per pixel (out_valid marks interior)
//  csr_*        in         write of image_width / image_height
//
// Each pixel goes from acceptance to a loaded result through gradient, multiply,
// 11 square-root iterations and output load; a new pixel is accepted only once
// the previous one has been loaded. The iterative square root is the longest step.
// Reset clears counters, window and control; line stores are not cleared.
// A waiting result is held in the output register; the next pixel is accepted
// meanwhile and stalls only at its own output load.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sobel_gradient_orientation_bin_core (
   input  logic                      clock,
   input  logic                      reset,
   sgob_req_if.sink                  req_channel,
   sgob_rsp_if.source                rsp_channel,
   input  logic                      csr_write_enable,
   input  sgob_pkg::csr_index_type   csr_index,
   input  logic [sgob_pkg::CFG_W-1:0] csr_write_data
);
   import sgob_pkg::*;

   typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_SQRT, S_DONE} state_type;

   localparam logic signed [CROSS_W-1:0] C_ONE = CROSS_W'(ONE_Q16);
   localparam logic signed [CROSS_W-1:0] C_T10 = CROSS_W'(T10);
   localparam logic signed [CROSS_W-1:0] C_T20 = CROSS_W'(T20);
   localparam logic signed [CROSS_W-1:0] C_T40 = CROSS_W'(T40);
   localparam logic signed [CROSS_W-1:0] C_T60 = CROSS_W'(T60);
   localparam logic [SQ_W-1:0] SQRT_BIT0 = SQ_W'(1) << (SQ_W - 2);

   logic [PIXEL_W-1:0] upper_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0] middle_mem [MAX_WIDTH];

   state_type state_ff, state_in;
   logic [CFG_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [IDX_W-1:0] col_ff, col_in, addr_ff, addr_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [47:0] win_ff, win_in;
   logic [PIXEL_W-1:0] pix_ff, pix_in, top_rd_ff, mid_rd_ff;
   logic interior_ff, interior_in;
   logic [COORD_W-1:0] ocol_ff, ocol_in, orow_ff, orow_in;
   logic signed [GRAD_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic signed [CROSS_W-1:0] c_ff [4];
   logic signed [CROSS_W-1:0] c_in [4];
   logic upper_ff, upper_in, gxz_ff, gxz_in;
   logic [SQ_W-1:0] n_ff, n_in, root_ff, root_in, bit_ff, bit_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic rv_ff, rv_in, ov_ff, ov_in;
   logic [COORD_W-1:0] rcol_ff, rcol_in, rrow_ff, rrow_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic [DIR_W-1:0] dir_ff, dir_in;

   logic accept;
   logic [EXT_W-1:0] eff_w, eff_h, col_next;
   logic [ROW_W:0] row_next;
   logic [23:0] lcol, mcol;
   logic signed [GRAD_W+1:0] sx_r, sx_l, sy_b, sy_t;
   logic signed [2*GRAD_W-1:0] gx2, gy2;
   logic signed [CROSS_W-1:0] px, py;
   logic [SQ_W-1:0] trial;
   logic [2:0] k;
   logic [DIR_W-1:0] dir_code;
   logic out_free;

   assign req_channel.ready = (state_ff == S_IDLE);
   assign accept = req_channel.valid && req_channel.ready;
   assign out_free = !rv_ff || rsp_channel.ready;

   // Clamp geometry
   always_comb begin
      eff_w = EXT_W'(width_ff);
      if (eff_w < EXT_W'(3)) eff_w = EXT_W'(3);
      if (eff_w > EXT_W'(MAX_WIDTH)) eff_w = EXT_W'(MAX_WIDTH);
      eff_h = EXT_W'(height_ff);
      if (eff_h < EXT_W'(3)) eff_h = EXT_W'(3);
      if (eff_h > EXT_W'(MAX_HEIGHT)) eff_h = EXT_W'(MAX_HEIGHT);
   end

   assign col_next = EXT_W'(col_ff) + EXT_W'(1);
   assign row_next = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign lcol = win_ff[47:24];
   assign mcol = win_ff[23:0];

   // Sobel sums over the window
   assign sx_r = $signed({5'd0, top_rd_ff}) + $signed({4'd0, mid_rd_ff, 1'b0})
               + $signed({5'd0, pix_ff});
   assign sx_l = $signed({5'd0, lcol[23:16]}) + $signed({4'd0, lcol[15:8], 1'b0})
               + $signed({5'd0, lcol[7:0]});
   assign sy_b = $signed({5'd0, lcol[7:0]}) + $signed({4'd0, mcol[7:0], 1'b0})
               + $signed({5'd0, pix_ff});
   assign sy_t = $signed({5'd0, lcol[23:16]}) + $signed({4'd0, mcol[23:16], 1'b0})
               + $signed({5'd0, top_rd_ff});

   assign gx2 = gx_ff * gx_ff;
   assign gy2 = gy_ff * gy_ff;
   assign px = CROSS_W'(gx_ff);
   assign py = (gy_ff >= 0) ? CROSS_W'(gy_ff) : -CROSS_W'(gy_ff);
   assign trial = root_ff + bit_ff;

   // Count sector edges passed and pick the code
   always_comb begin
      k = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (upper_ff ? (c_ff[i] >= 0) : (c_ff[i] > 0)) k = k + 3'd1;
      end
      dir_code = gxz_ff ? DIR_DIAG_POS : sector_code(upper_ff, k);
   end

   // Next-state logic
   always_comb begin
      state_in = state_ff;
      width_in = width_ff;
      height_in = height_ff;
      col_in = col_ff;
      row_in = row_ff;
      addr_in = addr_ff;
      win_in = win_ff;
      pix_in = pix_ff;
      interior_in = interior_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      gx_in = gx_ff;
      gy_in = gy_ff;
      c_in = c_ff;
      upper_in = upper_ff;
      gxz_in = gxz_ff;
      n_in = n_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      step_in = step_ff;
      rv_in = rv_ff && !rsp_channel.ready;
      ov_in = ov_ff;
      rcol_in = rcol_ff;
      rrow_in = rrow_ff;
      mag_in = mag_ff;
      dir_in = dir_ff;

      // Configuration writes restart the frame
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in = csr_write_data;
            CSR_IMAGE_HEIGHT: height_in = csr_write_data;
            default: ;
         endcase
         col_in = '0;
         row_in = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pix_in = req_channel.pixel;
               addr_in = col_ff;
               interior_in = (row_ff >= ROW_W'(2)) && (col_ff >= IDX_W'(2));
               ocol_in = COORD_W'(col_ff - IDX_W'(1));
               orow_in = COORD_W'(row_ff - ROW_W'(1));
               if (col_next >= eff_w) begin
                  col_in = '0;
                  row_in = (EXT_W'(row_next) >= eff_h) ? '0 : row_next[ROW_W-1:0];
               end else begin
                  col_in = col_next[IDX_W-1:0];
               end
               state_in = S_READ;
            end
         end
         S_READ: begin
            gx_in = GRAD_W'(sx_r - sx_l);
            gy_in = GRAD_W'(sy_b - sy_t);
            win_in = {mcol, top_rd_ff, mid_rd_ff, pix_ff};
            state_in = S_MUL;
         end
         S_MUL: begin
            n_in = SQ_W'($unsigned(gx2)) + SQ_W'($unsigned(gy2));
            root_in = '0;
            bit_in = SQRT_BIT0;
            step_in = STEP_W'(SQRT_STEPS - 1);
            upper_in = (gy_ff >= 0);
            gxz_in = (gx_ff == 0);
            c_in[0] = C_ONE * py - C_T20 * px;
            c_in[1] = C_ONE * py - C_T60 * px;
            c_in[2] = -(C_T10 * py) - C_ONE * px;
            c_in[3] = -(C_ONE * py) - C_T40 * px;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            // One digit of the bitwise square root
            if (n_ff >= trial) begin
               n_in = n_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rv_in = 1'b1;
               ov_in = interior_ff;
               rcol_in = interior_ff ? ocol_ff : '0;
               rrow_in = interior_ff ? orow_ff : '0;
               mag_in = interior_ff ? MAG_W'(root_ff) : '0;
               dir_in = interior_ff ? dir_code : '0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff <= '0;
         row_ff <= '0;
         win_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         win_ff <= win_in;
         rv_ff <= rv_in;
      end
      addr_ff <= addr_in;
      pix_ff <= pix_in;
      interior_ff <= interior_in;
      ocol_ff <= ocol_in;
      orow_ff <= orow_in;
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      c_ff <= c_in;
      upper_ff <= upper_in;
      gxz_ff <= gxz_in;
      n_ff <= n_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      step_ff <= step_in;
      ov_ff <= ov_in;
      rcol_ff <= rcol_in;
      rrow_ff <= rrow_in;
      mag_ff <= mag_in;
      dir_ff <= dir_in;
   end

   // Line stores: read on accept, write back in the gradient cycle (S_READ)
   always_ff @(posedge clock) begin
      if (accept) begin
         top_rd_ff <= upper_mem[col_ff];
         mid_rd_ff <= middle_mem[col_ff];
      end
      if (state_ff == S_READ) begin
         upper_mem[addr_ff] <= mid_rd_ff;
         middle_mem[addr_ff] <= pix_ff;
      end
   end

   assign rsp_channel.valid = rv_ff;
   assign rsp_channel.out_valid = ov_ff;
   assign rsp_channel.out_col = rcol_ff;
   assign rsp_channel.out_row = rrow_ff;
   assign rsp_channel.magnitude = mag_ff;
   assign rsp_channel.direction = dir_ff;

   `SGOB_ASSERT_NEXT(a_accept_reads, clock, reset, accept, state_ff == S_READ)
   `SGOB_ASSERT_NEXT(a_sqrt_ends, clock, reset, (state_ff == S_SQRT) && (step_ff == '0),
      state_ff == S_DONE)
   `SGOB_ASSERT_NOW(a_mag_bound, clock, reset, rv_ff, mag_ff <= MAG_W'(1442))
   `SGOB_ASSERT_NOW(a_border_zero, clock, reset, rv_ff && !ov_ff,
      (mag_ff == '0) && (dir_ff == '0))

endmodule
